// ----- rtl/agmu_pkg.sv -----
// shared constants, register codes and types of the adaptive gain momentum update
`default_nettype none

package agmu_pkg;

  localparam int COORD_W    = 16;
  localparam int DATA_W     = 32;
  localparam int ITER_W     = 20;
  localparam int SCALE_W    = 18;
  localparam int LR_W       = 32;
  localparam int FLOOR_W    = 17;
  localparam int MOM_W      = 16;
  localparam int COORD_SPAN = 1 << COORD_W;

  localparam int MAX_COORDS_DEF = 65536;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_STAGES     = 8;
  localparam int RMW_LAST_STAGE = 6;
  localparam int PIPE_SLOTS     = NUM_STAGES + 1;

  localparam logic [DATA_W-1:0] GAIN_ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] GAIN_INC = 32'd13107;
  localparam logic [MOM_W-1:0]  GAIN_DEC = 16'd52429;

  localparam logic [LR_W-1:0]    LR_RST     = 32'd13107200;
  localparam logic [FLOOR_W-1:0] FLOOR_RST  = 17'd6554;
  localparam logic [MOM_W-1:0]   EARLY_RST  = 16'd32768;
  localparam logic [MOM_W-1:0]   LATE_RST   = 16'd52429;
  localparam logic [ITER_W-1:0]  SWITCH_RST = 20'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE    = 3'd0,
    REG_GAIN_FLOOR       = 3'd1,
    REG_EARLY_MOMENTUM   = 3'd2,
    REG_LATE_MOMENTUM    = 3'd3,
    REG_SWITCH_ITERATION = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LR_W-1:0]    learning_rate;
    logic [FLOOR_W-1:0] gain_floor;
    logic [MOM_W-1:0]   early_momentum;
    logic [MOM_W-1:0]   late_momentum;
    logic [ITER_W-1:0]  switch_iteration;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]       coord_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] position;
    logic [ITER_W-1:0]        iteration_number;
    logic [SCALE_W-1:0]       step_scale;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]       out_index;
    logic signed [DATA_W-1:0] new_position;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic                     en;
    logic [COORD_W-1:0]       addr;
    logic [DATA_W-1:0]        gain;
    logic signed [DATA_W-1:0] vel;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- rtl/agmu_if.sv -----
// valid/ready channel interfaces for coordinate items and update results
`default_nettype none

interface agmu_in_if;
  import agmu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       coord_index;
  logic signed [DATA_W-1:0] gradient;
  logic signed [DATA_W-1:0] position;
  logic [ITER_W-1:0]        iteration_number;
  logic [SCALE_W-1:0]       step_scale;

  modport source (
    output valid, coord_index, gradient, position, iteration_number, step_scale,
    input  ready
  );
  modport sink (
    input  valid, coord_index, gradient, position, iteration_number, step_scale,
    output ready
  );
endinterface

interface agmu_out_if;
  import agmu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       out_index;
  logic signed [DATA_W-1:0] new_position;
  logic                     saturated;

  modport source (
    output valid, out_index, new_position, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_index, new_position, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/adaptive_gain_momentum_update.sv -----
// Adaptive gain momentum update, one embedding coordinate per transfer.
//
// in_ch carries index, gradient, position, iteration and step scale; out_ch
// returns index, new position and a saturation flag, one result per item in
// the order taken. cfg_we/cfg_index/cfg_wdata write the five registers
// (rate, gain floor, early and late momentum, switch iteration); write them
// only while idle, the block itself does not enforce it. Per-coordinate gain
// and velocity sit in two single-port-write memories with a registered read;
// each item reads at acceptance and writes back as it leaves stage 6.
// Throughput: one item per cycle unless store clearing, a hazard or a stalled
// out_ch holds input. An item whose index matches one still in the first six
// stages waits until that one has written back.
// Reset: registers return to their defaults and a sweep sets every entry to
// gain 1.0 and velocity 0; in_ch.ready stays low while the sweep covers the
// store depth (65536 by default), configuration writes are taken meanwhile.
// Stall: stages with a free slot ahead keep moving, so input is taken while a
// finished result waits on out_ch until all nine slots fill.
`default_nettype none

module adaptive_gain_momentum_update #(
  parameter int MAX_COORDS = agmu_pkg::MAX_COORDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  agmu_in_if.sink                              in_ch,
  agmu_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [agmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [agmu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import agmu_pkg::*;

  localparam int STORE_DEPTH = (MAX_COORDS > COORD_SPAN) ? COORD_SPAN : MAX_COORDS;

  cfg_t                     cfg;
  in_item_t                 in_item;
  out_item_t                out_item;
  mem_rd_t                  rd;
  mem_wr_t                  wr;
  logic [DATA_W-1:0]        rd_gain;
  logic signed [DATA_W-1:0] rd_vel;
  logic                     clearing;
  logic                     in_ready;
  logic                     out_valid;

  assign in_item.coord_index      = in_ch.coord_index;
  assign in_item.gradient         = in_ch.gradient;
  assign in_item.position         = in_ch.position;
  assign in_item.iteration_number = in_ch.iteration_number;
  assign in_item.step_scale       = in_ch.step_scale;
  assign in_ch.ready              = in_ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.out_index    = out_item.out_index;
  assign out_ch.new_position = out_item.new_position;
  assign out_ch.saturated    = out_item.saturated;

  agmu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  agmu_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (rd),
    .wr       (wr),
    .rd_gain  (rd_gain),
    .rd_vel   (rd_vel),
    .clearing (clearing)
  );

  agmu_pipe #(
    .MAX_COORDS (MAX_COORDS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clearing  (clearing),
    .in_valid  (in_ch.valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .rd        (rd),
    .rd_gain   (rd_gain),
    .rd_vel    (rd_vel),
    .wr        (wr),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire

// ----- rtl/agmu_cfg.sv -----
// configuration register file
`default_nettype none

module agmu_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [agmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [agmu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output agmu_pkg::cfg_t                       cfg
);
  import agmu_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE:    cfg_nxt.learning_rate    = cfg_wdata[LR_W-1:0];
        REG_GAIN_FLOOR:       cfg_nxt.gain_floor       = cfg_wdata[FLOOR_W-1:0];
        REG_EARLY_MOMENTUM:   cfg_nxt.early_momentum   = cfg_wdata[MOM_W-1:0];
        REG_LATE_MOMENTUM:    cfg_nxt.late_momentum    = cfg_wdata[MOM_W-1:0];
        REG_SWITCH_ITERATION: cfg_nxt.switch_iteration = cfg_wdata[ITER_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate    <= LR_RST;
      cfg_r.gain_floor       <= FLOOR_RST;
      cfg_r.early_momentum   <= EARLY_RST;
      cfg_r.late_momentum    <= LATE_RST;
      cfg_r.switch_iteration <= SWITCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/agmu_store.sv -----
// gain and velocity memories with registered read and clearing sweep after reset
`default_nettype none

module agmu_store #(
  parameter int DEPTH = agmu_pkg::COORD_SPAN
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire agmu_pkg::mem_rd_t                   rd,
  input  wire agmu_pkg::mem_wr_t                   wr,
  output logic [agmu_pkg::DATA_W-1:0]              rd_gain,
  output logic signed [agmu_pkg::DATA_W-1:0]       rd_vel,
  output logic                                     clearing
);
  import agmu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0]        gain_mem [DEPTH];
  logic signed [DATA_W-1:0] vel_mem  [DEPTH];

  logic          clearing_r;
  logic          clearing_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      gain_mem[clr_cnt_r] <= GAIN_ONE;
      vel_mem[clr_cnt_r]  <= '0;
    end else if (wr.en) begin
      gain_mem[wr.addr[AW-1:0]] <= wr.gain;
      vel_mem[wr.addr[AW-1:0]]  <= wr.vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_gain <= gain_mem[rd.addr[AW-1:0]];
      rd_vel  <= vel_mem[rd.addr[AW-1:0]];
    end
  end

  assign clearing = clearing_r;

endmodule

`default_nettype wire

// ----- rtl/agmu_pipe.sv -----
// eight stage update pipeline with hazard interlock and output register
`default_nettype none

module agmu_pipe #(
  parameter int MAX_COORDS = agmu_pkg::MAX_COORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire agmu_pkg::cfg_t                cfg,
  input  wire logic                          clearing,
  input  wire logic                          in_valid,
  input  wire agmu_pkg::in_item_t            in_item,
  output logic                               in_ready,
  output agmu_pkg::mem_rd_t                  rd,
  input  wire logic [agmu_pkg::DATA_W-1:0]   rd_gain,
  input  wire logic signed [agmu_pkg::DATA_W-1:0] rd_vel,
  output agmu_pkg::mem_wr_t                  wr,
  output logic                               out_valid,
  output agmu_pkg::out_item_t                out_item,
  input  wire logic                          out_ready
);
  import agmu_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0]       idx;
    logic                     in_range;
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] pos;
    logic [ITER_W-1:0]        iter;
    logic [SCALE_W-1:0]       scale;
    logic                     sat;
    logic                     grow;
    logic [DATA_W:0]          gsum;
    logic [47:0]              gprod;
    logic                     vneg;
    logic [47:0]              vprod;
    logic [DATA_W-1:0]        gain;
    logic signed [DATA_W-1:0] vm;
    logic [63:0]              rprod;
    logic [DATA_W-1:0]        rate;
    logic                     gneg;
    logic [DATA_W-1:0]        gmag;
    logic [63:0]              gprod2;
    logic signed [DATA_W-1:0] vnew;
    logic [49:0]              sprod;
  } stage_t;

  stage_t st_r   [1:NUM_STAGES];
  stage_t st_nxt [1:NUM_STAGES];

  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] vld_nxt;
  logic [NUM_STAGES:1] mv;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_r;
  out_item_t           out_nxt;
  logic                hazard;
  logic                acc;

  // transfer control and interlock against in-flight updates of the same entry
  always_comb begin
    mv[NUM_STAGES] = vld_r[NUM_STAGES] && (!out_valid_r || out_ready);
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      mv[k] = vld_r[k] && (!vld_r[k+1] || mv[k+1]);
    end
    hazard = 1'b0;
    for (int k = 1; k <= RMW_LAST_STAGE; k++) begin
      if (vld_r[k] && (st_r[k].idx == in_item.coord_index)) begin
        hazard = 1'b1;
      end
    end
    in_ready = !clearing && (!vld_r[1] || mv[1]) && !hazard;
    acc      = in_valid && in_ready;
    vld_nxt[1] = acc || (vld_r[1] && !mv[1]);
    for (int k = 2; k <= NUM_STAGES; k++) begin
      vld_nxt[k] = mv[k-1] || (vld_r[k] && !mv[k]);
    end
    out_valid_nxt = mv[NUM_STAGES] || (out_valid_r && !out_ready);
  end

  // datapath
  always_comb begin
    logic [DATA_W-1:0]        g_old;
    logic signed [DATA_W-1:0] v_old;
    logic                     g_zero;
    logic                     v_zero;
    logic [DATA_W-1:0]        vmag;
    logic [MOM_W-1:0]         mom;
    logic [DATA_W-1:0]        gain3;
    logic [47:0]              gq;
    logic [47:0]              vq;
    logic [63:0]              rsum;
    logic [63:0]              gsum2;
    logic [47:0]              rq;
    logic signed [49:0]       term;
    logic signed [49:0]       vfull;
    logic [DATA_W-1:0]        vmag8;
    logic [49:0]              ssum;
    logic [33:0]              sq;
    logic signed [35:0]       step;
    logic signed [35:0]       pfull;

    // stage 1: capture the item
    st_nxt[1]          = '0;
    st_nxt[1].idx      = in_item.coord_index;
    st_nxt[1].in_range = {5'b0, in_item.coord_index} < 21'(MAX_COORDS);
    st_nxt[1].grad     = in_item.gradient;
    st_nxt[1].pos      = in_item.position;
    st_nxt[1].iter     = in_item.iteration_number;
    st_nxt[1].scale    = in_item.step_scale;

    // stage 2: sign test, gain candidates, momentum product
    st_nxt[2] = st_r[1];
    g_old  = st_r[1].in_range ? rd_gain : GAIN_ONE;
    v_old  = st_r[1].in_range ? rd_vel : '0;
    g_zero = (st_r[1].grad == '0);
    v_zero = (v_old == '0);
    st_nxt[2].grow  = (g_zero != v_zero) ||
                      (!g_zero && (st_r[1].grad[DATA_W-1] != v_old[DATA_W-1]));
    st_nxt[2].gsum  = {1'b0, g_old} + {1'b0, GAIN_INC};
    st_nxt[2].gprod = {16'b0, g_old} * {32'b0, GAIN_DEC};
    vmag = v_old[DATA_W-1] ? unsigned'(-v_old) : unsigned'(v_old);
    mom  = (st_r[1].iter < cfg.switch_iteration) ? cfg.early_momentum : cfg.late_momentum;
    st_nxt[2].vneg  = v_old[DATA_W-1];
    st_nxt[2].vprod = {16'b0, vmag} * {32'b0, mom};
    st_nxt[2].gneg  = st_r[1].grad[DATA_W-1];
    st_nxt[2].gmag  = st_r[1].grad[DATA_W-1] ? unsigned'(-st_r[1].grad) : unsigned'(st_r[1].grad);

    // stage 3: new gain with floor, rounded momentum term
    st_nxt[3] = st_r[2];
    gq = st_r[2].gprod + 48'd32768;
    if (st_r[2].grow) begin
      if (st_r[2].gsum[DATA_W]) begin
        gain3 = '1;
        st_nxt[3].sat = 1'b1;
      end else begin
        gain3 = st_r[2].gsum[DATA_W-1:0];
      end
    end else begin
      gain3 = gq[47:16];
    end
    if (gain3 < {15'b0, cfg.gain_floor}) begin
      gain3 = {15'b0, cfg.gain_floor};
    end
    st_nxt[3].gain = gain3;
    vq = st_r[2].vprod + 48'd32768;
    st_nxt[3].vm = st_r[2].vneg ? -$signed(vq[47:16]) : $signed(vq[47:16]);

    // stage 4: effective rate product
    st_nxt[4] = st_r[3];
    st_nxt[4].rprod = {32'b0, st_r[3].gain} * {32'b0, cfg.learning_rate};

    // stage 5: round and clip the rate
    st_nxt[5] = st_r[4];
    rsum = st_r[4].rprod + 64'd32768;
    if (|rsum[63:48]) begin
      st_nxt[5].rate = '1;
      st_nxt[5].sat  = 1'b1;
    end else begin
      st_nxt[5].rate = rsum[47:16];
    end

    // stage 6: gradient step product
    st_nxt[6] = st_r[5];
    st_nxt[6].gprod2 = {32'b0, st_r[5].gmag} * {32'b0, st_r[5].rate};

    // stage 7: new velocity, clipped, written back on this transfer
    st_nxt[7] = st_r[6];
    gsum2 = st_r[6].gprod2 + 64'd32768;
    rq    = gsum2[63:16];
    term  = st_r[6].gneg ? -$signed({2'b0, rq}) : $signed({2'b0, rq});
    vfull = 50'(st_r[6].vm) - term;
    if (vfull > 50'sd2147483647) begin
      st_nxt[7].vnew = 32'sh7FFF_FFFF;
      st_nxt[7].sat  = 1'b1;
    end else if (vfull < -50'sd2147483648) begin
      st_nxt[7].vnew = 32'sh8000_0000;
      st_nxt[7].sat  = 1'b1;
    end else begin
      st_nxt[7].vnew = vfull[DATA_W-1:0];
    end

    // stage 8: position step product
    st_nxt[8] = st_r[7];
    vmag8 = st_r[7].vnew[DATA_W-1] ? unsigned'(-st_r[7].vnew) : unsigned'(st_r[7].vnew);
    st_nxt[8].vneg  = st_r[7].vnew[DATA_W-1];
    st_nxt[8].sprod = {18'b0, vmag8} * {32'b0, st_r[7].scale};

    // output: new position, clipped
    ssum  = st_r[8].sprod + 50'd32768;
    sq    = ssum[49:16];
    step  = st_r[8].vneg ? -$signed({2'b0, sq}) : $signed({2'b0, sq});
    pfull = 36'(st_r[8].pos) + step;
    out_nxt.out_index = st_r[8].idx;
    out_nxt.saturated = st_r[8].sat;
    if (pfull > 36'sd2147483647) begin
      out_nxt.new_position = 32'sh7FFF_FFFF;
      out_nxt.saturated    = 1'b1;
    end else if (pfull < -36'sd2147483648) begin
      out_nxt.new_position = 32'sh8000_0000;
      out_nxt.saturated    = 1'b1;
    end else begin
      out_nxt.new_position = pfull[DATA_W-1:0];
    end
  end

  always_comb begin
    rd.en   = acc;
    rd.addr = in_item.coord_index;
    wr.en   = mv[RMW_LAST_STAGE] && st_r[RMW_LAST_STAGE].in_range;
    wr.addr = st_r[RMW_LAST_STAGE].idx;
    wr.gain = st_r[RMW_LAST_STAGE].gain;
    wr.vel  = st_nxt[RMW_LAST_STAGE+1].vnew;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_r[1] <= st_nxt[1];
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (mv[k-1]) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (mv[NUM_STAGES]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ----- rtl/agmu_chk.sv -----
// port-level checker for the adaptive gain momentum update, bound to the top level
`default_nettype none

module agmu_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [agmu_pkg::COORD_W-1:0]       out_index,
  input wire logic signed [agmu_pkg::DATA_W-1:0] new_position,
  input wire logic                               saturated
);
  import agmu_pkg::*;

  localparam int CW = $clog2(PIPE_SLOTS + 1) + 1;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          in_xfer;
  logic          out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign cnt_nxt  = cnt_r + CW'(in_xfer) - CW'(out_xfer);

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_no_take: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during store clearing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) &&
    $stable(new_position) && $stable(saturated))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without an outstanding item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PIPE_SLOTS))
    else $error("more items outstanding than pipeline slots");

endmodule

bind adaptive_gain_momentum_update agmu_chk u_agmu_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_index    (out_ch.out_index),
  .new_position (out_ch.new_position),
  .saturated    (out_ch.saturated)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench of the adaptive gain momentum update: streams, predicts and checks results
module testbench;
  import agmu_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef enum {FLOW, COIN, HOLD, CADENCE} stall_mode_e;

  typedef struct {
    in_item_t                 item;
    bit                       typed;
    logic signed [DATA_W-1:0] want_pos;
    bit                       want_sat;
  } coord_case_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  agmu_in_if in_ch ();
  agmu_out_if out_ch ();

  adaptive_gain_momentum_update uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow registers and per-coordinate state
  logic [LR_W-1:0]    rate_q;
  logic [FLOOR_W-1:0] floor_q;
  logic [MOM_W-1:0]   early_q;
  logic [MOM_W-1:0]   late_q;
  logic [ITER_W-1:0]  switch_q;
  bit [DATA_W-1:0]    gain_mem [COORD_SPAN];
  int                 vel_mem [COORD_SPAN];

  out_item_t   pending_positions[$];
  coord_case_t directed_cases[$];
  int          mismatches = 0;
  int          updates_seen = 0;
  int          clipped_seen = 0;

  stall_mode_e stall_mode = FLOW;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] round_q16(input logic [63:0] mag);
    return (mag + 64'd32768) >> 16;
  endfunction

  function automatic longint scale_round(input longint a, input logic [63:0] b);
    logic [63:0] mag;
    longint r;
    mag = (a < 0) ? -a : a;
    r = longint'(round_q16(mag * b));
    return (a < 0) ? -r : r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip_word(input longint v, inout bit sat);
    if (v > WORD_MAX) begin
      sat = 1'b1;
      return WORD_MAX[DATA_W-1:0];
    end
    if (v < WORD_MIN) begin
      sat = 1'b1;
      return WORD_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic int sign_of(input longint v);
    return int'(v > 0) - int'(v < 0);
  endfunction

  function automatic out_item_t next_position(input in_item_t it);
    out_item_t r;
    bit in_store;
    bit sat;
    logic [63:0] gain;
    logic [63:0] rate;
    logic [63:0] mom;
    longint vel;
    longint grad;
    logic signed [DATA_W-1:0] vnew;
    logic signed [DATA_W-1:0] pnew;
    in_store = int'(it.coord_index) < MAX_COORDS_DEF;
    sat = 1'b0;
    grad = longint'($signed(it.gradient));
    gain = in_store ? {32'd0, gain_mem[it.coord_index]} : {32'd0, GAIN_ONE};
    vel = in_store ? longint'(vel_mem[it.coord_index]) : 64'sd0;
    if (sign_of(grad) != sign_of(vel)) begin
      gain = gain + {32'd0, GAIN_INC};
      if (gain > 64'h0000_0000_FFFF_FFFF) begin
        gain = 64'h0000_0000_FFFF_FFFF;
        sat = 1'b1;
      end
    end else begin
      gain = round_q16(gain * GAIN_DEC);
    end
    if (gain < floor_q) gain = {47'd0, floor_q};
    rate = round_q16({32'd0, rate_q} * gain);
    if (rate > 64'h0000_0000_FFFF_FFFF) begin
      rate = 64'h0000_0000_FFFF_FFFF;
      sat = 1'b1;
    end
    mom = (it.iteration_number < switch_q) ? {48'd0, early_q} : {48'd0, late_q};
    vnew = clip_word(scale_round(vel, mom) - scale_round(grad, rate), sat);
    pnew = clip_word(longint'($signed(it.position))
                     + scale_round(longint'(vnew), {46'd0, it.step_scale}), sat);
    if (in_store) begin
      gain_mem[it.coord_index] = gain[DATA_W-1:0];
      vel_mem[it.coord_index] = vnew;
    end
    r.out_index = it.coord_index;
    r.new_position = pnew;
    r.saturated = sat;
    return r;
  endfunction

  function automatic void add_case(input logic [COORD_W-1:0] idx, input logic [DATA_W-1:0] grad,
                                   input logic [DATA_W-1:0] pos, input logic [ITER_W-1:0] iter,
                                   input logic [SCALE_W-1:0] scale, input bit typed = 1'b0,
                                   input logic [DATA_W-1:0] want_pos = '0,
                                   input bit want_sat = 1'b0);
    coord_case_t c;
    c.item.coord_index = idx;
    c.item.gradient = grad;
    c.item.position = pos;
    c.item.iteration_number = iter;
    c.item.step_scale = scale;
    c.typed = typed;
    c.want_pos = want_pos;
    c.want_sat = want_sat;
    directed_cases = {directed_cases, c};
  endfunction

  function automatic logic [DATA_W-1:0] edge_word();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic in_item_t random_coord();
    in_item_t it;
    int near;
    case ($urandom_range(0, 9))
      0, 1: it.coord_index = 16'($urandom);
      2: it.coord_index = 16'hFFFF - 16'($urandom_range(0, 3));
      default: it.coord_index = 16'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 6))
      0: it.gradient = '0;
      1, 2: it.gradient = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      3: it.gradient = $urandom;
      4: it.gradient = edge_word();
      default: it.gradient = $signed($urandom) >>> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 4))
      0, 1: it.position = $urandom;
      2: it.position = edge_word();
      default: it.position = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
    case ($urandom_range(0, 3))
      0, 1: begin
        near = int'(switch_q) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 20'hFFFFF) near = 20'hFFFFF;
        it.iteration_number = 20'(near);
      end
      2: it.iteration_number = 20'($urandom_range(0, 2 * int'(switch_q) + 1));
      default: it.iteration_number = 20'($urandom_range(0, 20'hFFFFF));
    endcase
    case ($urandom_range(0, 4))
      0: it.step_scale = '0;
      1: it.step_scale = 18'h1_0000;
      2: it.step_scale = 18'($urandom_range(0, 18'h0_3FFF));
      default: it.step_scale = 18'($urandom_range(0, 18'h3_FFFF));
    endcase
    return it;
  endfunction

  task automatic transfer_coord(input in_item_t it, input bit typed = 1'b0,
                                input logic [DATA_W-1:0] want_pos = '0,
                                input bit want_sat = 1'b0);
    out_item_t want;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.coord_index = it.coord_index;
    in_ch.gradient = it.gradient;
    in_ch.position = it.position;
    in_ch.iteration_number = it.iteration_number;
    in_ch.step_scale = it.step_scale;
    do @(posedge clk); while (!in_ch.ready);
    want = next_position(it);
    if (typed) begin
      want.new_position = want_pos;
      want.saturated = want_sat;
    end
    pending_positions = {pending_positions, want};
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    case (r)
      REG_LEARNING_RATE:    rate_q = v;
      REG_GAIN_FLOOR:       floor_q = v[FLOOR_W-1:0];
      REG_EARLY_MOMENTUM:   early_q = v[MOM_W-1:0];
      REG_LATE_MOMENTUM:    late_q = v[MOM_W-1:0];
      REG_SWITCH_ITERATION: switch_q = v[ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // receiver stalls in stretches of differing character
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end else begin
      stall_left = stall_left - 1;
    end
    stall_tick = stall_tick + 1;
    case (stall_mode)
      FLOW:    out_ch.ready = 1'b1;
      COIN:    out_ch.ready = 1'($urandom_range(0, 1));
      HOLD:    out_ch.ready = 1'b0;
      default: out_ch.ready = (stall_tick % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_positions.size() == 0) begin
        $error("result for coordinate %0d with no update pending", out_ch.out_index);
        mismatches++;
      end else begin
        want = pending_positions.pop_front();
        updates_seen++;
        if (out_ch.saturated) clipped_seen++;
        if (out_ch.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, out_ch.out_index);
          mismatches++;
        end
        if (out_ch.new_position !== want.new_position) begin
          $error("new_position of coordinate %0d: expected %0d, got %0d",
                 want.out_index, want.new_position, out_ch.new_position);
          mismatches++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated of coordinate %0d: expected %0b, got %0b",
                 want.out_index, want.saturated, out_ch.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (600000) @(posedge clk);
    $display("[adaptive_gain_momentum_update] ERROR");
    $finish;
  end

  initial begin
    int left;
    int burst;
    int gap;
    int phase;
    logic [CFG_DATA_W-1:0] lr_v, floor_v, early_v, late_v, switch_v;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LEARNING_RATE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.coord_index = '0;
    in_ch.gradient = '0;
    in_ch.position = '0;
    in_ch.iteration_number = '0;
    in_ch.step_scale = '0;
    out_ch.ready = 1'b0;
    rate_q = LR_RST;
    floor_q = FLOOR_RST;
    early_q = EARLY_RST;
    late_q = LATE_RST;
    switch_q = SWITCH_RST;
    for (int i = 0; i < COORD_SPAN; i++) begin
      gain_mem[i] = GAIN_ONE;
      vel_mem[i] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // fresh entries at reset settings, extremes and clipping
    add_case(16'd0, 32'd0, 32'h0003_0039, 20'd0, 18'h3FFFF, 1'b1, 32'h0003_0039, 1'b0);
    add_case(16'hFFFF, 32'h8000_0000, 32'd0, 20'hFFFFF, 18'd0, 1'b1, 32'd0, 1'b1);
    add_case(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd0, 18'h3FFFF, 1'b1,
             32'h8000_0000, 1'b1);
    add_case(16'd1, 32'd0, 32'h8000_0000, 20'd0, 18'h3FFFF, 1'b1, 32'h8000_0000, 1'b0);
    add_case(16'd3, 32'h8000_0000, 32'h7FFF_FFFF, 20'd0, 18'h3FFFF, 1'b1,
             32'h7FFF_FFFF, 1'b1);
    add_case(16'd3, 32'h8000_0000, 32'h8000_0000, 20'd300, 18'd1);
    add_case(16'd2, 32'h0001_0000, 32'd0, 20'd0, 18'h1_0000);
    add_case(16'd2, 32'h0001_0000, 32'd0, 20'd249, 18'h1_0000);
    add_case(16'd2, -32'sd65536, 32'h0001_0000, 20'd250, 18'h1_0000);
    add_case(16'd2, 32'hFFFF_FFFF, 32'd0, 20'hFFFFF, 18'h3FFFF);
    add_case(16'd4, 32'h7FFF_FFFF, 32'd12345, 20'd0, 18'h1_0000);
    add_case(16'd4, 32'd0, 32'd0, 20'd0, 18'd0);
    add_case(16'd4, 32'd0, 32'd0, 20'd1000, 18'h0_FFFF);
    add_case(16'd5, 32'd1, 32'hFFFF_FFFF, 20'd0, 18'd1);
    add_case(16'd5, 32'hFFFF_FFFF, 32'd1, 20'd0, 18'd2);
    add_case(16'd0, 32'h0001_8000, 32'd0, 20'd250, 18'h2_0000);
    add_case(16'hFFFF, 32'd0, 32'h7FFF_FFFF, 20'd249, 18'h1_0000);
    // same entry repeated, gain decays towards the floor
    for (int k = 0; k < 4; k++)
      add_case(16'd6, 32'd0, 32'h0000_1000 << k, 20'd10, 18'h1_0000);

    foreach (directed_cases[i])
      transfer_coord(directed_cases[i].item, directed_cases[i].typed,
                     directed_cases[i].want_pos, directed_cases[i].want_sat);
    hold_off(1);
    settle();

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin
          lr_v = 32'hFFFF_FFFF;
          floor_v = 32'h0001_FFFF;
          early_v = 32'h0000_FFFF;
          late_v = 32'h0000_FFFF;
          switch_v = 32'h000F_FFFF;
        end
        1: begin
          lr_v = '0;
          floor_v = '0;
          early_v = '0;
          late_v = '0;
          switch_v = '0;
        end
        2: begin
          lr_v = LR_RST;
          floor_v = 32'h0001_0000;
          early_v = '0;
          late_v = 32'h0000_FFFF;
          switch_v = $urandom_range(1, 64);
        end
        default: begin
          lr_v = $urandom >> $urandom_range(0, 31);
          floor_v = $urandom_range(0, 32'h0001_0000);
          early_v = $urandom_range(0, 16'hFFFF);
          late_v = $urandom_range(0, 16'hFFFF);
          switch_v = $urandom_range(0, 2000);
        end
      endcase
      write_reg(REG_LEARNING_RATE, lr_v);
      write_reg(REG_GAIN_FLOOR, floor_v);
      write_reg(REG_EARLY_MOMENTUM, early_v);
      write_reg(REG_LATE_MOMENTUM, late_v);
      write_reg(REG_SWITCH_ITERATION, switch_v);
      @(negedge clk);
      cfg_we = 1'b0;

      // sender works in bursts with gaps between them
      left = 76;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && left > 0; k++) begin
          transfer_coord(random_coord());
          left--;
        end
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        hold_off(gap);
      end
      settle();
    end

    $display("ran %0d coordinate updates over %0d register settings",
             updates_seen, phase + 1);
    $display("%0d of them came back clipped", clipped_seen);
    if (mismatches == 0)
      $display("[adaptive_gain_momentum_update] OK");
    else
      $display("[adaptive_gain_momentum_update] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/agmu_pkg.sv
rtl/agmu_if.sv
rtl/agmu_cfg.sv
rtl/agmu_store.sv
rtl/agmu_pipe.sv
rtl/adaptive_gain_momentum_update.sv
rtl/agmu_chk.sv
sim/testbench.sv
